// ===== design/pirc_pkg.sv =====
// Shared types and constants for the index record checker.
`default_nettype none

package pirc_pkg;

  localparam int HEADER_BYTES = 24;
  localparam int PATH_W       = 13;
  localparam int ABI_W        = 16;
  localparam int CFG_DATA_W   = 16;
  localparam int CFG_IDX_W    = 1;

  localparam logic [31:0] REC_MAGIC    = 32'h4150_5256;
  localparam logic [15:0] REC_VERSION  = 16'd2;
  localparam logic [15:0] REC_HDR_SIZE = 16'd24;
  localparam logic [7:0]  CH_SLASH     = 8'h2F;
  localparam logic [7:0]  CH_DOT       = 8'h2E;
  localparam logic [PATH_W-1:0] PATH_SAT   = 13'd4096;
  localparam logic [PATH_W-1:0] PATH_RESET = 13'd4096;

  // Header byte positions at which a complete field has been shifted in.
  localparam logic [4:0] POS_MAGIC    = 5'd3;
  localparam logic [4:0] POS_VERSION  = 5'd5;
  localparam logic [4:0] POS_HSIZE    = 5'd7;
  localparam logic [4:0] POS_MAJOR    = 5'd9;
  localparam logic [4:0] POS_MINOR    = 5'd11;
  localparam logic [4:0] POS_PATCH    = 5'd13;
  localparam logic [4:0] POS_ABI      = 5'd15;
  localparam logic [4:0] POS_ABI_MIN  = 5'd17;
  localparam logic [4:0] POS_RESERVED = 5'd19;
  localparam logic [4:0] POS_BUILD    = 5'd23;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EXPECTED_ABI = 1'b0,
    CFG_PATH_LIMIT   = 1'b1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_OK       = 4'd0,
    ST_SHORT    = 4'd1,
    ST_MAGIC    = 4'd2,
    ST_VERSION  = 4'd3,
    ST_HSIZE    = 4'd4,
    ST_ABI      = 4'd5,
    ST_RESERVED = 4'd6,
    ST_LONG     = 4'd7,
    ST_PATH     = 4'd8
  } status_t;

endpackage

`default_nettype wire

// ===== design/provider_index_record_checker.sv =====
// Top level of the index record checker: byte stream in, one verdict per record out.
`default_nettype none

// Streams an index record one byte per item, last byte flagged, and returns
// one result per record carrying the header fields, the path length and a
// status code for the first failed check. One byte is accepted every cycle while
// in_ready is high; the result is presented in the cycle after its last byte is
// taken, from an output register, and in_ready drops only while that register
// holds a result the consumer has not yet taken. All per-byte work is a short
// update of counters and small registers. The configuration port is always ready.
module provider_index_record_checker #(
  parameter int MAX_RECORD_BYTES = 4120
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [pirc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [pirc_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [7:0]                          in_byte_value,
  input  wire logic                                in_last_byte,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [3:0]                               out_status,
  output logic [15:0]                              out_major_version,
  output logic [15:0]                              out_minor_version,
  output logic [15:0]                              out_patch_version,
  output logic [15:0]                              out_abi_rev,
  output logic [31:0]                              out_build_tag,
  output logic [pirc_pkg::PATH_W-1:0]              out_path_bytes
);

  localparam int CNT_W  = $clog2(MAX_RECORD_BYTES + 2);
  localparam int WIDE_W = (CNT_W > pirc_pkg::PATH_W) ? CNT_W : pirc_pkg::PATH_W;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_RECORD_BYTES);
  localparam logic [CNT_W-1:0] CNT_HDR = CNT_W'(pirc_pkg::HEADER_BYTES);

  function automatic logic char_allowed(input logic [7:0] v);
    char_allowed = (v >= 8'h61 && v <= 8'h7A) || (v >= 8'h41 && v <= 8'h5A) ||
                   (v >= 8'h30 && v <= 8'h39) || v == pirc_pkg::CH_DOT ||
                   v == 8'h5F || v == 8'h2D;
  endfunction

  // Configuration registers.
  logic [pirc_pkg::ABI_W-1:0]  expected_abi_r;
  logic [pirc_pkg::PATH_W-1:0] path_limit_r;

  // Record state.
  logic [CNT_W-1:0]         byte_count_r, byte_count_nxt;
  pirc_pkg::status_t        first_error_r, first_error_nxt;
  logic [31:0]              header_shift_r, header_shift_nxt;
  logic [15:0]              major_r, major_nxt;
  logic [15:0]              minor_r, minor_nxt;
  logic [15:0]              patch_r, patch_nxt;
  logic [15:0]              abi_rev_r, abi_rev_nxt;
  logic [31:0]              build_tag_r, build_tag_nxt;
  logic [1:0]               seg_len_r, seg_len_nxt;
  logic [7:0]               prev0_r, prev0_nxt;
  logic [7:0]               prev1_r, prev1_nxt;

  // Result register.
  logic                        out_valid_r;
  pirc_pkg::status_t           status_r, status_nxt;
  logic [15:0]                 out_major_r, out_minor_r, out_patch_r, out_abi_rev_r;
  logic [31:0]                 out_build_tag_r;
  logic [pirc_pkg::PATH_W-1:0] path_len_r, path_len_nxt;

  logic in_take;
  logic res_load;
  logic res_ok;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign in_take   = in_valid && in_ready;
  assign res_load  = in_take && in_last_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_abi_r <= '0;
      path_limit_r   <= pirc_pkg::PATH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (pirc_pkg::cfg_idx_t'(cfg_index))
        pirc_pkg::CFG_EXPECTED_ABI: expected_abi_r <= cfg_data[pirc_pkg::ABI_W-1:0];
        pirc_pkg::CFG_PATH_LIMIT:   path_limit_r   <= cfg_data[pirc_pkg::PATH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [CNT_W-1:0]  idx;
    logic [15:0]       low;
    logic              bad_seg;
    logic [CNT_W-1:0]  praw;
    logic [WIDE_W-1:0] praw_w;

    idx              = byte_count_r;
    header_shift_nxt = header_shift_r;
    first_error_nxt  = first_error_r;
    major_nxt        = major_r;
    minor_nxt        = minor_r;
    patch_nxt        = patch_r;
    abi_rev_nxt      = abi_rev_r;
    build_tag_nxt    = build_tag_r;
    seg_len_nxt      = seg_len_r;
    prev0_nxt        = prev0_r;
    prev1_nxt        = prev1_r;
    bad_seg          = 1'b0;
    low              = '0;

    if (idx < CNT_HDR) begin
      header_shift_nxt = {header_shift_r[23:0], in_byte_value};
      low = header_shift_nxt[15:0];
      case (idx[4:0])
        pirc_pkg::POS_MAGIC:    bad_seg = 1'b0;
        pirc_pkg::POS_MAJOR:    major_nxt = low;
        pirc_pkg::POS_MINOR:    minor_nxt = low;
        pirc_pkg::POS_PATCH:    patch_nxt = low;
        pirc_pkg::POS_ABI_MIN:  abi_rev_nxt = low;
        pirc_pkg::POS_BUILD:    build_tag_nxt = header_shift_nxt;
        default: ;
      endcase
      // Header checks; only the first failure is kept.
      if (first_error_r == pirc_pkg::ST_OK) begin
        case (idx[4:0])
          pirc_pkg::POS_MAGIC:
            if (header_shift_nxt != pirc_pkg::REC_MAGIC) first_error_nxt = pirc_pkg::ST_MAGIC;
          pirc_pkg::POS_VERSION:
            if (low != pirc_pkg::REC_VERSION) first_error_nxt = pirc_pkg::ST_VERSION;
          pirc_pkg::POS_HSIZE:
            if (low != pirc_pkg::REC_HDR_SIZE) first_error_nxt = pirc_pkg::ST_HSIZE;
          pirc_pkg::POS_ABI:
            if (low != expected_abi_r) first_error_nxt = pirc_pkg::ST_ABI;
          pirc_pkg::POS_RESERVED:
            if (low != 16'd0) first_error_nxt = pirc_pkg::ST_RESERVED;
          default: ;
        endcase
      end
    end else begin
      if (in_byte_value == pirc_pkg::CH_SLASH) begin
        // A slash closes a segment that must not be empty, "." or "..".
        bad_seg = (seg_len_r == 2'd0) ||
                  (seg_len_r == 2'd1 && prev0_r == pirc_pkg::CH_DOT) ||
                  (seg_len_r == 2'd2 && prev0_r == pirc_pkg::CH_DOT &&
                   prev1_r == pirc_pkg::CH_DOT) ||
                  in_last_byte;
        seg_len_nxt = 2'd0;
      end else begin
        seg_len_nxt = (seg_len_r == 2'd3) ? 2'd3 : seg_len_r + 2'd1;
        bad_seg = !char_allowed(in_byte_value) ||
                  (in_last_byte && in_byte_value == pirc_pkg::CH_DOT &&
                   (seg_len_nxt == 2'd1 ||
                    (seg_len_nxt == 2'd2 && prev0_r == pirc_pkg::CH_DOT)));
      end
      if (bad_seg && first_error_r == pirc_pkg::ST_OK) first_error_nxt = pirc_pkg::ST_PATH;
      prev1_nxt = prev0_r;
      prev0_nxt = in_byte_value;
    end

    byte_count_nxt = (byte_count_r <= CNT_MAX) ? byte_count_r + 1'b1 : byte_count_r;

    // Verdict for the record, used only when this is the last byte.
    praw   = (byte_count_nxt >= CNT_HDR) ? byte_count_nxt - CNT_HDR : '0;
    praw_w = WIDE_W'(praw);
    path_len_nxt = (praw_w > WIDE_W'(pirc_pkg::PATH_SAT)) ? pirc_pkg::PATH_SAT
                                                          : praw_w[pirc_pkg::PATH_W-1:0];
    if (byte_count_nxt < CNT_HDR + 1'b1) begin
      status_nxt = pirc_pkg::ST_SHORT;
    end else if (first_error_nxt != pirc_pkg::ST_OK && first_error_nxt != pirc_pkg::ST_PATH) begin
      status_nxt = first_error_nxt;
    end else if (byte_count_nxt > CNT_MAX || praw_w >= WIDE_W'(path_limit_r)) begin
      status_nxt = pirc_pkg::ST_LONG;
    end else begin
      status_nxt = first_error_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || res_load) begin
      byte_count_r   <= '0;
      first_error_r  <= pirc_pkg::ST_OK;
      header_shift_r <= '0;
      major_r        <= '0;
      minor_r        <= '0;
      patch_r        <= '0;
      abi_rev_r      <= '0;
      build_tag_r    <= '0;
      seg_len_r      <= '0;
      prev0_r        <= '0;
      prev1_r        <= '0;
    end else if (in_take) begin
      byte_count_r   <= byte_count_nxt;
      first_error_r  <= first_error_nxt;
      header_shift_r <= header_shift_nxt;
      major_r        <= major_nxt;
      minor_r        <= minor_nxt;
      patch_r        <= patch_nxt;
      abi_rev_r      <= abi_rev_nxt;
      build_tag_r    <= build_tag_nxt;
      seg_len_r      <= seg_len_nxt;
      prev0_r        <= prev0_nxt;
      prev1_r        <= prev1_nxt;
    end
  end

  assign res_ok = (status_nxt == pirc_pkg::ST_OK);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Header fields are reported only for a record that passed every check.
  always_ff @(posedge clk) begin
    if (res_load) begin
      status_r        <= status_nxt;
      out_major_r     <= res_ok ? major_nxt : '0;
      out_minor_r     <= res_ok ? minor_nxt : '0;
      out_patch_r     <= res_ok ? patch_nxt : '0;
      out_abi_rev_r   <= res_ok ? abi_rev_nxt : '0;
      out_build_tag_r <= res_ok ? build_tag_nxt : '0;
      path_len_r      <= path_len_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_major_version = out_major_r;
  assign out_minor_version = out_minor_r;
  assign out_patch_version = out_patch_r;
  assign out_abi_rev       = out_abi_rev_r;
  assign out_build_tag     = out_build_tag_r;
  assign out_path_bytes    = path_len_r;

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |=> out_valid && byte_count_r == '0 && first_error_r == pirc_pkg::ST_OK)
    else $error("last byte did not produce a result or clear the record");

  a_fields_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != pirc_pkg::ST_OK |->
      out_major_version == '0 && out_minor_version == '0 && out_patch_version == '0 &&
      out_abi_rev == '0 && out_build_tag == '0)
    else $error("header fields reported for a failed record");

  a_short_no_path: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == pirc_pkg::ST_SHORT |-> out_path_bytes == '0)
    else $error("short record reports a path length");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    byte_count_r <= CNT_MAX + 1'b1)
    else $error("byte counter passed its saturation point");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_path_bytes))
    else $error("pending result changed before it was taken");

endmodule

`default_nettype wire

// ===== verif/provider_index_record_checker_tb.sv =====
// Testbench for the index record checker: directed and random records checked against a predictor.
`timescale 1ns / 1ps

module provider_index_record_checker_tb;

  localparam int REC_MAX = 4120;
  // Letters and digits come first, so the first 62 entries are plain segment characters.
  localparam string PATH_CHARS =
    "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789._-";
  localparam int N_PATH_CHARS = 65;
  localparam int N_ALNUM = 62;

  typedef logic [7:0] byte_q_t[$];

  typedef struct packed {
    pirc_pkg::status_t           status;
    logic [15:0]                 major;
    logic [15:0]                 minor;
    logic [15:0]                 patch;
    logic [15:0]                 abi_rev;
    logic [31:0]                 build;
    logic [pirc_pkg::PATH_W-1:0] path_bytes;
  } verdict_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  pirc_pkg::cfg_idx_t              cfg_index = pirc_pkg::CFG_EXPECTED_ABI;
  logic [pirc_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic [7:0]                      in_byte_value = '0;
  logic                            in_last_byte = 1'b0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic [3:0]                      out_status;
  logic [15:0]                     out_major_version;
  logic [15:0]                     out_minor_version;
  logic [15:0]                     out_patch_version;
  logic [15:0]                     out_abi_rev;
  logic [31:0]                     out_build_tag;
  logic [pirc_pkg::PATH_W-1:0]     out_path_bytes;

  int send_idle_pct = 34;
  int recv_idle_pct = 68;
  int failures = 0;

  // Predictor copy of the registers and of the record in progress.
  logic [15:0]                 abi_cfg = 16'd0;
  logic [pirc_pkg::PATH_W-1:0] limit_cfg = pirc_pkg::PATH_RESET;
  logic [12:0]                 seen_bytes;
  pirc_pkg::status_t           rec_err;
  logic [31:0]                 hdr_window;
  logic [31:0]                 captured [5];
  int                          seg_len;
  logic [7:0]                  last_ch;
  logic [7:0]                  prior_ch;

  verdict_t pending_verdicts[$];
  verdict_t want;

  provider_index_record_checker #(
    .MAX_RECORD_BYTES(REC_MAX)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte_value    (in_byte_value),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_major_version(out_major_version),
    .out_minor_version(out_minor_version),
    .out_patch_version(out_patch_version),
    .out_abi_rev      (out_abi_rev),
    .out_build_tag    (out_build_tag),
    .out_path_bytes   (out_path_bytes)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic void clear_record();
    seen_bytes = '0;
    rec_err = pirc_pkg::ST_OK;
    hdr_window = '0;
    foreach (captured[k]) captured[k] = '0;
    seg_len = 0;
    last_ch = '0;
    prior_ch = '0;
  endfunction

  function automatic void note_err(input pirc_pkg::status_t code);
    if (rec_err == pirc_pkg::ST_OK) rec_err = code;
  endfunction

  // Advances the predictor by one accepted byte and queues a verdict on the last one.
  function automatic void track_byte(input logic [7:0] v, input logic last);
    verdict_t    res;
    logic [15:0] low;
    int          praw;
    if (seen_bytes < pirc_pkg::HEADER_BYTES) begin
      hdr_window = {hdr_window[23:0], v};
      low = hdr_window[15:0];
      case (seen_bytes)
        pirc_pkg::POS_MAGIC:
          if (hdr_window != pirc_pkg::REC_MAGIC) note_err(pirc_pkg::ST_MAGIC);
        pirc_pkg::POS_VERSION:
          if (low != pirc_pkg::REC_VERSION) note_err(pirc_pkg::ST_VERSION);
        pirc_pkg::POS_HSIZE:
          if (low != pirc_pkg::REC_HDR_SIZE) note_err(pirc_pkg::ST_HSIZE);
        pirc_pkg::POS_MAJOR:    captured[0] = low;
        pirc_pkg::POS_MINOR:    captured[1] = low;
        pirc_pkg::POS_PATCH:    captured[2] = low;
        pirc_pkg::POS_ABI:      if (low != abi_cfg) note_err(pirc_pkg::ST_ABI);
        pirc_pkg::POS_ABI_MIN:  captured[3] = low;
        pirc_pkg::POS_RESERVED: if (low != 16'd0) note_err(pirc_pkg::ST_RESERVED);
        pirc_pkg::POS_BUILD:    captured[4] = hdr_window;
        default: ;
      endcase
    end else if (v == pirc_pkg::CH_SLASH) begin
      if (seg_len == 0 || (seg_len == 1 && last_ch == pirc_pkg::CH_DOT) ||
          (seg_len == 2 && last_ch == pirc_pkg::CH_DOT && prior_ch == pirc_pkg::CH_DOT))
        note_err(pirc_pkg::ST_PATH);
      seg_len = 0;
      if (last) note_err(pirc_pkg::ST_PATH);
      prior_ch = last_ch;
      last_ch = v;
    end else begin
      if (!((v >= "a" && v <= "z") || (v >= "A" && v <= "Z") || (v >= "0" && v <= "9") ||
            v == pirc_pkg::CH_DOT || v == "_" || v == "-"))
        note_err(pirc_pkg::ST_PATH);
      if (seg_len < 3) seg_len++;
      // A path may not end in a "." or ".." segment.
      if (last && ((seg_len == 1 && v == pirc_pkg::CH_DOT) ||
                   (seg_len == 2 && v == pirc_pkg::CH_DOT && last_ch == pirc_pkg::CH_DOT)))
        note_err(pirc_pkg::ST_PATH);
      prior_ch = last_ch;
      last_ch = v;
    end
    if (seen_bytes <= REC_MAX) seen_bytes++;
    if (!last) return;

    res = '0;
    praw = (seen_bytes >= pirc_pkg::HEADER_BYTES) ?
           int'(seen_bytes) - pirc_pkg::HEADER_BYTES : 0;
    res.path_bytes = (praw > int'(pirc_pkg::PATH_SAT)) ? pirc_pkg::PATH_SAT
                                                       : pirc_pkg::PATH_W'(praw);
    if (seen_bytes < pirc_pkg::HEADER_BYTES + 1)
      res.status = pirc_pkg::ST_SHORT;
    else if (rec_err != pirc_pkg::ST_OK && rec_err != pirc_pkg::ST_PATH)
      res.status = rec_err;
    else if (seen_bytes > REC_MAX || praw >= int'(limit_cfg))
      res.status = pirc_pkg::ST_LONG;
    else if (rec_err == pirc_pkg::ST_PATH)
      res.status = pirc_pkg::ST_PATH;
    else begin
      res.status = pirc_pkg::ST_OK;
      res.major = captured[0][15:0];
      res.minor = captured[1][15:0];
      res.patch = captured[2][15:0];
      res.abi_rev = captured[3][15:0];
      res.build = captured[4];
    end
    pending_verdicts.push_back(res);
    clear_record();
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      failures++;
    end
  endtask

  // Result side: compare each taken result with the oldest verdict, then pick the next ready.
  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      if (pending_verdicts.size() == 0) begin
        $error("result item arrived with no verdict pending");
        failures++;
      end else begin
        want = pending_verdicts.pop_front();
        check_field("status", want.status, out_status);
        check_field("major_version", want.major, out_major_version);
        check_field("minor_version", want.minor, out_minor_version);
        check_field("patch_version", want.patch, out_patch_version);
        check_field("abi_rev", want.abi_rev, out_abi_rev);
        check_field("build_tag", want.build, out_build_tag);
        check_field("path_bytes", want.path_bytes, out_path_bytes);
      end
    end
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic byte_q_t make_header(input logic [15:0] abi, input logic [15:0] major,
                                          input logic [15:0] minor, input logic [15:0] patch,
                                          input logic [15:0] abi_min, input logic [31:0] build);
    logic [31:0] words [6];
    byte_q_t     h;
    words = '{pirc_pkg::REC_MAGIC, {pirc_pkg::REC_VERSION, pirc_pkg::REC_HDR_SIZE},
              {major, minor}, {patch, abi}, {abi_min, 16'h0000}, build};
    foreach (words[w])
      for (int k = 3; k >= 0; k--) h.push_back(words[w][8*k +: 8]);
    return h;
  endfunction

  function automatic byte_q_t std_header();
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    a = $urandom;
    b = $urandom;
    c = $urandom;
    return make_header(abi_cfg, a[15:0], a[31:16], b[15:0], b[31:16], c);
  endfunction

  function automatic void add_text(ref byte_q_t q, input string s);
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
  endfunction

  // Letters or digits with a slash after every eight, never at the end; always a legal path.
  function automatic void add_alnum_path(ref byte_q_t q, input int n);
    for (int i = 0; i < n; i++)
      q.push_back((i % 9 == 8 && i != n - 1) ? pirc_pkg::CH_SLASH
                                              : PATH_CHARS[$urandom_range(N_ALNUM - 1)]);
  endfunction

  function automatic void add_clean_path(ref byte_q_t q);
    string   tokens [6] = '{"...", ".x", "y.", "..a", "b..", "-_."};
    byte_q_t seg;
    int      nseg;
    int      len;
    nseg = $urandom_range(1, 4);
    for (int s = 0; s < nseg; s++) begin
      if (s > 0) q.push_back(pirc_pkg::CH_SLASH);
      if ($urandom_range(3) == 0) begin
        add_text(q, tokens[$urandom_range(5)]);
      end else begin
        seg.delete();
        len = $urandom_range(1, 5);
        for (int i = 0; i < len; i++) seg.push_back(PATH_CHARS[$urandom_range(N_PATH_CHARS - 1)]);
        // A segment made only of one or two dots is refused, so keep this one legal.
        if (len <= 2 && seg[0] == pirc_pkg::CH_DOT && seg[len-1] == pirc_pkg::CH_DOT)
          seg[0] = "q";
        foreach (seg[i]) q.push_back(seg[i]);
      end
    end
  endfunction

  task automatic send_byte(input logic [7:0] v, input logic last);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_byte_value <= v;
    in_last_byte <= last;
    do @(posedge clk); while (!in_ready);
    track_byte(v, last);
  endtask

  task automatic send_record(input byte_q_t rec);
    for (int i = 0; i < rec.size(); i++) send_byte(rec[i], i == rec.size() - 1);
  endtask

  task automatic send_path_record(input string path);
    byte_q_t rec;
    rec = std_header();
    add_text(rec, path);
    send_record(rec);
  endtask

  // Stops sending and lets every pending result drain before going on.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic configure(input logic [15:0] abi, input logic [pirc_pkg::PATH_W-1:0] limit);
    cfg_valid <= 1'b1;
    cfg_index <= pirc_pkg::CFG_EXPECTED_ABI;
    cfg_data <= abi;
    do @(posedge clk); while (!cfg_ready);
    abi_cfg = abi;
    cfg_index <= pirc_pkg::CFG_PATH_LIMIT;
    cfg_data <= pirc_pkg::CFG_DATA_W'(limit);
    do @(posedge clk); while (!cfg_ready);
    limit_cfg = limit;
    cfg_valid <= 1'b0;
  endtask

  // Runs with the register values from reset.
  task automatic test_path_rules();
    string      good_paths [6] = '{"a", "a/b.c_d-E9", "...", ".a/b.", "..x/x..", "_/-/Z"};
    string      bad_paths [10] = '{"/a", "a/", "a//b", ".", "..", "./a", "a/./b", "a/.",
                                   "../a", "a/.."};
    logic [7:0] odd_chars [3] = '{8'h2C, 8'h60, 8'hFF};
    byte_q_t    rec;
    foreach (good_paths[i]) send_path_record(good_paths[i]);
    foreach (bad_paths[i]) send_path_record(bad_paths[i]);
    foreach (odd_chars[i]) begin
      rec = std_header();
      add_text(rec, "ab");
      rec.push_back(odd_chars[i]);
      add_text(rec, "c");
      send_record(rec);
    end
  endtask

  task automatic test_header_checks();
    logic [4:0] hdr_checks [5] = '{pirc_pkg::POS_MAGIC, pirc_pkg::POS_VERSION,
                                   pirc_pkg::POS_HSIZE, pirc_pkg::POS_ABI,
                                   pirc_pkg::POS_RESERVED};
    byte_q_t    rec;
    wait_drained();
    configure(16'h5A3C, pirc_pkg::PATH_RESET);
    rec = make_header(abi_cfg, '0, '0, '0, '0, '0);
    add_text(rec, "a");
    send_record(rec);
    rec = make_header(abi_cfg, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    add_text(rec, "Zz9");
    send_record(rec);
    foreach (hdr_checks[i]) begin
      rec = std_header();
      rec[hdr_checks[i]] ^= 8'h01;
      add_text(rec, "ok");
      send_record(rec);
    end
    // With several faults the earliest check in byte order is the one reported.
    rec = std_header();
    rec[pirc_pkg::POS_ABI] ^= 8'h10;
    rec[0] ^= 8'h80;
    add_text(rec, "/");
    send_record(rec);
    rec = std_header();
    rec[pirc_pkg::POS_VERSION] = 8'h00;
    add_text(rec, "a//b");
    send_record(rec);
    // A record needs at least one path byte after the header.
    rec.delete();
    rec.push_back(8'h41);
    send_record(rec);
    rec = std_header();
    void'(rec.pop_back());
    send_record(rec);
    rec = std_header();
    send_record(rec);
    rec[1] = 8'h00;
    send_record(rec);
  endtask

  task automatic test_limits();
    byte_q_t rec;
    wait_drained();
    // A zero limit makes every complete record with a good header too long, ahead of a bad path.
    configure(16'hFFFF, '0);
    send_path_record("a");
    send_path_record("/");
    rec = std_header();
    rec[2] = 8'h00;
    add_text(rec, "a");
    send_record(rec);
    send_record(std_header());
    wait_drained();
    configure(16'h0000, 13'd3);
    send_path_record("ab");
    send_path_record("abc");
    send_path_record("abcd");
    send_path_record("a/");
  endtask

  task automatic random_record(output byte_q_t rec);
    int kind;
    int n;
    kind = $urandom_range(99);
    rec = std_header();
    if (kind < 85) begin
      if ($urandom_range(3) == 0) add_alnum_path(rec, $urandom_range(1, 30));
      else add_clean_path(rec);
    end
    if (kind >= 60 && kind < 75) begin
      case ($urandom_range(5))
        0: rec[$urandom_range(pirc_pkg::HEADER_BYTES, rec.size() - 1)] = 8'($urandom_range(255));
        1: rec.insert(pirc_pkg::HEADER_BYTES, pirc_pkg::CH_SLASH);
        2: rec.push_back(pirc_pkg::CH_SLASH);
        3: add_text(rec, "//z");
        4: add_text(rec, "/./z");
        default: begin
          if ($urandom_range(1)) add_text(rec, "/..");
          else add_text(rec, "/.");
        end
      endcase
    end else if (kind >= 75 && kind < 85) begin
      rec[$urandom_range(pirc_pkg::HEADER_BYTES - 1)] ^= 8'($urandom_range(1, 255));
    end else if (kind >= 85 && kind < 93) begin
      n = $urandom_range(1, pirc_pkg::HEADER_BYTES);
      while (rec.size() > n) void'(rec.pop_back());
    end else if (kind >= 93) begin
      rec.delete();
      n = $urandom_range(1, 40);
      for (int i = 0; i < n; i++) rec.push_back(8'($urandom_range(255)));
    end
  endtask

  task automatic test_random(input int send_pct, input int recv_pct,
                             input logic [15:0] abi, input logic [pirc_pkg::PATH_W-1:0] limit);
    byte_q_t rec;
    int      sent_bytes;
    int      records;
    wait_drained();
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    configure(abi, limit);
    sent_bytes = 0;
    records = 0;
    while (sent_bytes < 40 || records < 2) begin
      random_record(rec);
      if ($urandom_range(9) == 0) wait_drained();
      send_record(rec);
      sent_bytes += rec.size();
      records++;
    end
  endtask

  initial begin
    clear_record();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_path_rules();
    test_header_checks();
    test_limits();
    test_random(34, 68, 16'($urandom), pirc_pkg::PATH_RESET);
    test_random(68, 34, 16'($urandom), pirc_pkg::PATH_W'($urandom_range(1, 16)));
    test_random(0, 0, 16'($urandom), pirc_pkg::PATH_W'($urandom_range(0, 40)));
    in_valid <= 1'b0;
    for (int i = 0; i < 100000 && pending_verdicts.size() != 0; i++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (pending_verdicts.size() != 0) begin
      $error("%0d verdicts never matched by a result item", pending_verdicts.size());
      failures++;
    end
    if (failures == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #4_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
